@@ rtl/core/bcf_pkg.sv @@
// Shared types and constants for the class fusion block.
`timescale 1ns / 1ps
package bcf_pkg;
  localparam int NumClasses = 16;
  localparam int NumEntries = 4096;
  localparam int ProbBits   = 16;
  localparam int ClassW     = 4;
  localparam int EntryW     = 12;
  localparam int SumW       = 21;
  localparam int AddrW      = EntryW + ClassW;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FUSE = 1'b1;
  localparam logic CFG_CLASSES = 1'b0;
  localparam logic CFG_MINCONF = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_FREAD, ST_FMUL, ST_FWRITE,
    ST_NREAD, ST_NWAIT, ST_DIV, ST_NWRITE, ST_EMIT
  } bcf_state_t;

  typedef struct packed {
    logic take_item;
    logic load_wr;
    logic mem_rd;
    logic mul_go;
    logic fuse_wr;
    logic norm_init;
    logic div_start;
    logic norm_wr;
    logic out_load;
  } bcf_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic is_fuse;
    logic last_class;
    logic div_done;
    logic norm_last;
    logic sum_zero;
    logic out_busy;
  } bcf_stat_t;
endpackage

@@ rtl/core/bcf_ctrl.sv @@
// Controller state machine for the class fusion block.
`timescale 1ns / 1ps
module bcf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  bcf_pkg::bcf_stat_t stat,
  output bcf_pkg::bcf_cmd_t  cmd
);
  bcf_pkg::bcf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bcf_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (!stat.item_ok) state_nxt = bcf_pkg::ST_IDLE;
          else if (stat.is_fuse) state_nxt = bcf_pkg::ST_FREAD;
          else state_nxt = bcf_pkg::ST_LOAD;
        end
      end
      bcf_pkg::ST_LOAD:   state_nxt = bcf_pkg::ST_IDLE;
      bcf_pkg::ST_FREAD:  state_nxt = bcf_pkg::ST_FMUL;
      bcf_pkg::ST_FMUL:   state_nxt = bcf_pkg::ST_FWRITE;
      bcf_pkg::ST_FWRITE: begin
        if (!stat.last_class) state_nxt = bcf_pkg::ST_IDLE;
        else if (stat.sum_zero) state_nxt = bcf_pkg::ST_EMIT;
        else state_nxt = bcf_pkg::ST_NREAD;
      end
      bcf_pkg::ST_NREAD:  state_nxt = bcf_pkg::ST_NWAIT;
      bcf_pkg::ST_NWAIT:  state_nxt = bcf_pkg::ST_DIV;
      bcf_pkg::ST_DIV:    if (stat.div_done) state_nxt = bcf_pkg::ST_NWRITE;
      bcf_pkg::ST_NWRITE: state_nxt = stat.norm_last ? bcf_pkg::ST_EMIT : bcf_pkg::ST_NREAD;
      bcf_pkg::ST_EMIT:   if (!stat.out_busy) state_nxt = bcf_pkg::ST_IDLE;
      default:            state_nxt = bcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bcf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take_item = in_tvalid;
      end
      bcf_pkg::ST_LOAD:   cmd.load_wr = 1'b1;
      bcf_pkg::ST_FREAD:  cmd.mem_rd = 1'b1;
      bcf_pkg::ST_FMUL:   cmd.mul_go = 1'b1;
      bcf_pkg::ST_FWRITE: begin
        cmd.fuse_wr = 1'b1;
        cmd.norm_init = 1'b1;
      end
      bcf_pkg::ST_NREAD:  cmd.mem_rd = 1'b1;
      bcf_pkg::ST_NWAIT:  cmd.div_start = 1'b1;
      bcf_pkg::ST_DIV:    ;
      bcf_pkg::ST_NWRITE: cmd.norm_wr = 1'b1;
      bcf_pkg::ST_EMIT:   cmd.out_load = !stat.out_busy;
      default:            ;
    endcase
  end
endmodule

@@ rtl/core/bcf_datapath.sv @@
// Table memory, multiplier, serial divider, arg-max and output register.
`timescale 1ns / 1ps
module bcf_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [32:0]        in_tdata,
  input  logic [4:0]         classes_in_use,
  input  logic [15:0]        min_confidence,
  input  bcf_pkg::bcf_cmd_t  cmd,
  output bcf_pkg::bcf_stat_t stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata
);
  localparam int PB = bcf_pkg::ProbBits;
  localparam int NW = PB + bcf_pkg::SumW; // dividend width

  logic [PB-1:0] mem [0:(1<<bcf_pkg::AddrW)-1];
  logic [PB-1:0] rd_r;

  logic                      cmd_r;
  logic [bcf_pkg::EntryW-1:0] ent_r;
  logic [bcf_pkg::ClassW-1:0] cls_r;
  logic [PB-1:0]             val_r;
  logic [PB-1:0]             prod_r;
  logic [bcf_pkg::SumW-1:0]  sum_r, sum_nxt;
  logic [bcf_pkg::ClassW-1:0] k_r;
  logic [bcf_pkg::ClassW-1:0] last_c;
  logic [4:0]                n_act;

  logic [NW-1:0]             quo_r, rem_r;
  logic [NW:0]               trial;
  logic [5:0]                dcnt_r;
  logic                      dbusy_r;
  logic [PB-1:0]             best_r, q_sat;
  logic [bcf_pkg::ClassW-1:0] bcls_r;
  logic                      ov_r;

  logic                      ovalid_r;
  logic [39:0]               odata_r;

  logic [bcf_pkg::AddrW-1:0] rd_addr, wr_addr;
  logic [PB-1:0]             wr_data;
  logic                      wr_en;

  wire                     in_cmd = in_tdata[0];
  wire [bcf_pkg::ClassW-1:0] in_cls = in_tdata[16:13];

  always_comb begin
    n_act = classes_in_use;
    if (n_act < 5'd2) n_act = 5'd2;
    if (n_act > 5'(bcf_pkg::NumClasses)) n_act = 5'(bcf_pkg::NumClasses);
    last_c = bcf_pkg::ClassW'(n_act - 5'd1);
  end

  assign stat.is_fuse    = in_cmd == bcf_pkg::CMD_FUSE;
  assign stat.item_ok    = (in_cmd == bcf_pkg::CMD_LOAD) || ({1'b0, in_cls} < n_act);
  assign stat.last_class = cls_r == last_c;
  assign stat.sum_zero   = sum_r == '0;
  assign stat.div_done   = dbusy_r && dcnt_r == '0;
  assign stat.norm_last  = k_r == last_c;
  assign stat.out_busy   = ovalid_r;

  assign rd_addr = cmd_r ? {ent_r, k_r} : {ent_r, cls_r};
  assign wr_addr = cmd.norm_wr ? {ent_r, k_r} : {ent_r, cls_r};
  assign wr_en   = cmd.load_wr || cmd.fuse_wr || cmd.norm_wr;

  always_comb begin
    wr_data = q_sat;
    if (cmd.load_wr) wr_data = val_r;
    else if (cmd.fuse_wr) wr_data = prod_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.mem_rd) rd_r <= mem[rd_addr];
  end

  // cmd_r doubles as "normalising" flag once fuse write is done
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      val_r <= in_tdata[32:17];
    end
  end

  wire [2*PB-1:0] mul = rd_r * val_r;
  assign sum_nxt = (cls_r == '0 ? '0 : sum_r) + bcf_pkg::SumW'(mul[2*PB-1:PB]);

  always_comb begin
    q_sat = (quo_r[NW-1:PB] != '0) ? '1 : quo_r[PB-1:0];
  end

  assign trial = {rem_r, quo_r[NW-1]} - {{(NW+1-bcf_pkg::SumW){1'b0}}, sum_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      cmd_r    <= 1'b0;
      dbusy_r  <= 1'b0;
      ovalid_r <= 1'b0;
      ent_r    <= '0;
    end else begin
      if (cmd.take_item) begin
        cmd_r <= 1'b0;
        ent_r <= in_tdata[12:1];
        cls_r <= in_cls;
      end
      if (cmd.mul_go) begin
        prod_r <= mul[2*PB-1:PB];
        sum_r  <= sum_nxt;
      end
      if (cmd.norm_init) begin
        cmd_r  <= 1'b1;
        k_r    <= '0;
        best_r <= '0;
        bcls_r <= '0;
      end
      if (cmd.div_start) begin
        quo_r   <= NW'(rd_r) << PB;
        rem_r   <= '0;
        dcnt_r  <= 6'(NW);
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dcnt_r != '0) begin
        if (!trial[NW]) begin
          rem_r <= trial[NW-1:0];
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[NW-2:0], quo_r[NW-1]};
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 6'd1;
      end
      if (cmd.norm_wr) begin
        dbusy_r <= 1'b0;
        if (q_sat >= best_r) begin
          best_r <= q_sat;
          bcls_r <= k_r;
        end
        k_r <= k_r + 1'b1;
      end
      if (cmd.out_load) begin
        ovalid_r <= 1'b1;
        odata_r  <= stat.sum_zero ? {7'd0, 16'd0, 4'd0, 1'b0, ent_r}
                  : {7'd0, best_r, bcls_r, best_r >= min_confidence, ent_r};
        sum_r    <= '0;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule

@@ rtl/core/bayesian_class_fusion.sv @@
// Top level of the Bayesian class fusion block.
`timescale 1ns / 1ps
// Loads and fuses per-entry class probabilities held in a 64K x 16 table.
// A load writes the table, a fuse reads, multiplies and writes back, and an
// ignored fuse is dropped; the fuse of the last class in use then, unless the
// product sum is zero, normalises every class through a bit-serial divider
// (read, wait, divide, write back per class) before one result transfer;
// an entry may also wait for the previous result to be taken.
module bayesian_class_fusion (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd, entry_index, class_index, value, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_entry, class_found, best_class, best_prob, pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [4:0]  classes_r;
  logic [15:0] minconf_r;
  bcf_pkg::bcf_cmd_t  cmd;
  bcf_pkg::bcf_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      classes_r <= 5'd16;
      minconf_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bcf_pkg::CFG_CLASSES) classes_r <= cfg_data[4:0];
      else minconf_r <= cfg_data;
    end
  end

  bcf_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .stat, .cmd
  );

  bcf_datapath u_dp (
    .clk, .rst_n, .in_tdata(in_tdata[32:0]),
    .classes_in_use(classes_r), .min_confidence(minconf_r),
    .cmd, .stat, .out_tvalid, .out_tready, .out_tdata
  );

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_go |-> !in_tready) else $error("item taken during fuse");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !cmd.out_load) else $error("double result");
endmodule

@@ test/tb.sv @@
// Self-checking testbench for bayesian_class_fusion: stream driver, monitor and fusion predictor.
`timescale 1ns / 1ps
module tb;
  typedef struct {
    logic       cmd;
    logic [11:0] entry;
    logic [3:0]  cls;
    logic [15:0] value;
  } elem_t;

  typedef struct {
    logic [11:0] entry;
    logic        found;
    logic [3:0]  cls;
    logic [15:0] prob;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // cmd, entry_index, class_index, value, pad
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // result_entry, class_found, best_class, best_prob, pad
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  bayesian_class_fusion u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] prob_mem [0:65535];
  bit          loaded   [0:65535];
  logic [63:0] acc_sum;
  logic [11:0] last_entry;
  logic [4:0]  cls_reg;
  logic [15:0] conf_reg;

  elem_t    pending_elems[$];
  verdict_t verdicts_due[$];

  int  errors = 0;
  int  sent_elems = 0;
  int  fusions_done = 0;
  int  zero_sums = 0;
  int  hold_reqs = 0;
  bit  run_started = 0;
  bit  no_idle = 0;
  bit  in_fire = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_served = 0;
  int  hold_left = 0;

  function automatic int class_count();
    int n;
    n = int'(cls_reg);
    if (n < 2) n = 2;
    if (n > bcf_pkg::NumClasses) n = bcf_pkg::NumClasses;
    return n;
  endfunction

  function automatic bit fuse_predict(input elem_t it, output verdict_t r);
    int          n;
    int          base;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] best;
    logic [3:0]  best_k;
    bit          found;
    n = class_count();
    base = int'({it.entry, 4'b0});
    best = 0;
    best_k = 0;
    found = 0;
    r = '{default: 0};
    if (it.cmd == bcf_pkg::CMD_LOAD) begin
      prob_mem[base + it.cls] = it.value;
      loaded[base + it.cls] = 1;
      return 0;
    end
    if (it.cls >= n) return 0;
    if (it.cls == 0) acc_sum = 0;
    prod = (64'(prob_mem[base + it.cls]) * 64'(it.value)) >> bcf_pkg::ProbBits;
    prob_mem[base + it.cls] = prod[15:0];
    acc_sum += prod;
    last_entry = it.entry;
    if (it.cls != n - 1) return 0;
    if (acc_sum != 0) begin
      for (int k = 0; k < n; k++) begin
        q = (64'(prob_mem[base + k]) << bcf_pkg::ProbBits) / acc_sum;
        if (q > 64'hFFFF) q = 64'hFFFF;
        prob_mem[base + k] = q[15:0];
        if (q >= best) begin
          best = q;
          best_k = k[3:0];
        end
      end
      found = (best >= 64'(conf_reg));
    end else begin
      zero_sums++;
    end
    acc_sum = 0;
    r.entry = last_entry;
    r.found = found;
    r.cls = best_k;
    r.prob = best[15:0];
    return 1;
  endfunction

  task automatic push_elem(input logic cmd, input int e, input int c, input int v);
    elem_t    it;
    verdict_t r;
    it.cmd = cmd;
    it.entry = e[11:0];
    it.cls = c[3:0];
    it.value = v[15:0];
    pending_elems.insert(pending_elems.size(), it);
    sent_elems++;
    if (fuse_predict(it, r)) begin
      verdicts_due.insert(verdicts_due.size(), r);
      fusions_done++;
    end
  endtask

  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return $urandom_range(0, 15);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int pick_entry();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    if (r < 6) return $urandom_range(0, 15);
    return $urandom_range(0, 4095);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one entry: loads, then an in-order fuse sequence that may be broken or mixed
  task automatic gen_entry();
    int e;
    int e2;
    int n;
    int stop;
    int fill;
    n = class_count();
    e = pick_entry();
    e2 = e;
    fill = $urandom_range(0, 3);
    for (int c = 0; c < bcf_pkg::NumClasses; c++) begin
      if (c < n && (!loaded[{e[11:0], 4'b0} + c] || $urandom_range(0, 1)))
        push_elem(bcf_pkg::CMD_LOAD, e, c, fill == 0 ? 0 : pick_value());
      else if (c >= n && $urandom_range(0, 7) == 0)
        push_elem(bcf_pkg::CMD_LOAD, e, c, pick_value());
    end
    if ($urandom_range(0, 9) == 0) begin
      e2 = pick_entry();
      for (int c = 0; c < n; c++) push_elem(bcf_pkg::CMD_LOAD, e2, c, pick_value());
    end
    stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 2) : n - 1;
    for (int c = 0; c <= stop; c++) begin
      if (n < bcf_pkg::NumClasses && $urandom_range(0, 9) == 0)
        push_elem(bcf_pkg::CMD_FUSE, pick_entry(),
                  $urandom_range(n, bcf_pkg::NumClasses - 1), pick_value());
      push_elem(bcf_pkg::CMD_FUSE, (c == n - 1) ? e2 : e, c, fill == 0 ? pick_value() :
                ($urandom_range(0, 5) == 0 ? 0 : pick_value()));
    end
  endtask

  task automatic cfg_write(input logic idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bcf_pkg::CFG_CLASSES) cls_reg = val[4:0];
    else conf_reg = val[15:0];
  endtask

  task automatic drain();
    while (pending_elems.size() != 0 || in_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic report(input string what, input verdict_t got, input verdict_t want);
    errors++;
    $display("error %0t %s: got e=%0d f=%0b c=%0d p=%0h want e=%0d f=%0b c=%0d p=%0h",
             $time, what, got.entry, got.found, got.cls, got.prob,
             want.entry, want.found, want.cls, want.prob);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sender
  always @(posedge clk) in_fire <= in_tvalid && in_tready;

  always @(negedge clk) begin
    if (!run_started) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_elems.size() != 0) begin
      elem_t it;
      it = pending_elems.pop_front();
      in_tdata <= {7'b0, it.value, it.cls, it.entry, it.cmd};
      in_tvalid <= 1'b1;
      in_gap <= pick_gap();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left <= 3000;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      verdict_t got;
      verdict_t want;
      got.entry = out_tdata[11:0];
      got.found = out_tdata[12];
      got.cls = out_tdata[16:13];
      got.prob = out_tdata[32:17];
      if (verdicts_due.size() == 0) begin
        want = '{default: 0};
        report("unexpected transfer", got, want);
      end else begin
        want = verdicts_due.pop_front();
        if (got.entry !== want.entry) report("result_entry", got, want);
        else if (got.found !== want.found) report("class_found", got, want);
        else if (got.cls !== want.cls) report("best_class", got, want);
        else if (got.prob !== want.prob) report("best_prob", got, want);
      end
    end
  end

  initial begin
    int cls_set  [6] = '{4, 2, 0, 31, 16, 3};
    int conf_set [6] = '{0, 65535, 32768, 1, 0, 49152};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bcf_pkg::CFG_CLASSES;
    cfg_data = '0;
    acc_sum = 0;
    last_entry = 0;
    cls_reg = 16;
    conf_reg = 0;
    for (int i = 0; i < 65536; i++) begin
      prob_mem[i] = 0;
      loaded[i] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_started = 1;

    // directed: reset class count, ties, zero sum, ignored class, extremes
    for (int c = 0; c < bcf_pkg::NumClasses; c++)
      push_elem(bcf_pkg::CMD_LOAD, 4095, c, 16'h8000);
    for (int c = 0; c < bcf_pkg::NumClasses; c++)
      push_elem(bcf_pkg::CMD_FUSE, 4095, c, 16'hFFFF);
    drain();
    cfg_write(bcf_pkg::CFG_CLASSES, 4);
    cfg_write(bcf_pkg::CFG_MINCONF, 16'h4000);
    for (int c = 0; c < 4; c++) push_elem(bcf_pkg::CMD_LOAD, 0, c, 0);
    for (int c = 0; c < 4; c++) push_elem(bcf_pkg::CMD_FUSE, 0, c, 16'hFFFF);
    push_elem(bcf_pkg::CMD_FUSE, 0, 9, 16'hFFFF);
    push_elem(bcf_pkg::CMD_LOAD, 0, 2, 16'hFFFF);
    push_elem(bcf_pkg::CMD_LOAD, 0, 3, 16'hFFFF);
    for (int c = 0; c < 4; c++) push_elem(bcf_pkg::CMD_FUSE, 0, c, 16'h1234);
    drain();

    for (int p = 0; p < 6; p++) begin
      cfg_write(bcf_pkg::CFG_CLASSES, cls_set[p]);
      cfg_write(bcf_pkg::CFG_MINCONF, conf_set[p]);
      no_idle = (p == 2);
      if (p == 1) hold_reqs++;
      while (sent_elems < 150 + 110 * p) gen_entry();
      drain();
    end

    $display("covered %0d element transfers, %0d completed entries, %0d with zero sum",
             sent_elems, fusions_done, zero_sums);
    if (errors == 0) begin
      $display("bayesian_class_fusion: match");
    end else begin
      $display("bayesian_class_fusion: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bayesian_class_fusion: mismatch");
    $finish;
  end
endmodule
